// ===== hdl/tcme_pkg.sv =====
package tcme_pkg;

  localparam int MAX_WRITE_BYTES = 16;
  localparam int POS_W = $clog2(MAX_WRITE_BYTES + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] STEP_RESET = 7'd10;

  localparam logic [2:0] EV_MOVE_X = 3'd0;
  localparam logic [2:0] EV_MOVE_Y = 3'd1;
  localparam logic [2:0] EV_LEFT = 3'd2;
  localparam logic [2:0] EV_RIGHT = 3'd3;
  localparam logic [2:0] EV_SYNC = 3'd4;

  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_SEQ = 3'd1;
  localparam logic [2:0] MODE_X = 3'd2;
  localparam logic [2:0] MODE_Y = 3'd3;
  localparam logic [2:0] MODE_LCLICK = 3'd4;
  localparam logic [2:0] MODE_RCLICK = 3'd5;

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_CASE = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_Y = 8'h79;
  localparam logic [7:0] CH_L = 8'h6C;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_Q = 8'h71;
  localparam logic [7:0] CH_UP_Q = 8'h51;
  localparam logic [7:0] CH_W = 8'h77;
  localparam logic [7:0] CH_UP_W = 8'h57;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0] count;
    logic [2:0][2:0] kind;
    logic [2:0] level;
    logic [31:0] mag;
    logic neg;
  } evt_entry_t;

endpackage

// ===== hdl/text_command_to_mouse_events_unit.sv =====
// A byte's first event passes the queue slot, the current-entry register and the output
// register. Throughput: one byte per cycle while each byte yields at most one event and
// the output does not stall; a byte's events (at most 3) share the single output register.
// A 2-entry queue between byte decoder and event sequencer absorbs output stalls.
// Reset (rst, synchronous): clears write state, queue and output; step_distance = 10.
module text_command_to_mouse_events_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [tcme_pkg::IN_TDATA_W-1:0] s_axis_tdata, // [7:0] data_byte
  input  logic s_axis_tlast,                            // end_of_write
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [tcme_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [31:0] event_value
  output logic [tcme_pkg::OUT_TUSER_W-1:0] m_axis_tuser, // [2:0] event_kind
  output logic m_axis_tlast,                             // last_of_run
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tcme_pkg::STEP_W-1:0] cfg_data           // step_distance
);

  logic [tcme_pkg::STEP_W-1:0] step_distance;
  logic q_ready, q_valid, push, q_pop;
  tcme_pkg::evt_entry_t push_entry, q_entry;
  logic [2:0] ev_kind;
  logic [31:0] ev_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_distance <= tcme_pkg::STEP_RESET;
    end else if (cfg_valid) begin
      step_distance <= cfg_data;
    end
  end

  tcme_front u_front (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .step_distance(step_distance),
    .q_ready(q_ready),
    .push(push),
    .push_entry(push_entry)
  );

  tcme_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .ready(q_ready),
    .valid(q_valid),
    .pop(q_pop),
    .pop_entry(q_entry)
  );

  tcme_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_entry(q_entry),
    .q_pop(q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  assign ev_kind = m_axis_tuser;
  assign ev_value = m_axis_tdata;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ev_kind <= tcme_pkg::EV_SYNC)
    else $error("event kind out of range");

  a_sync_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ev_kind == tcme_pkg::EV_SYNC) |-> ev_value == 32'd0)
    else $error("sync event with nonzero value");

  a_button_level: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (ev_kind == tcme_pkg::EV_LEFT || ev_kind == tcme_pkg::EV_RIGHT))
      |-> ev_value[31:1] == 31'd0)
    else $error("button event with level other than 0 or 1");

endmodule

// ===== hdl/tcme_front.sv =====
module tcme_front (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [tcme_pkg::IN_TDATA_W-1:0] s_axis_tdata, // [7:0] data_byte
  input  logic s_axis_tlast,
  input  logic [tcme_pkg::STEP_W-1:0] step_distance,
  input  logic q_ready,
  output logic push,
  output tcme_pkg::evt_entry_t push_entry
);

  logic [tcme_pkg::POS_W-1:0] pos, pos_next;
  logic [2:0] mode, mode_next;
  logic stopped, stopped_next;
  logic neg, neg_next;
  logic [31:0] acc, acc_next;
  logic prev_sync, prev_sync_next;

  logic [7:0] c, lc;
  logic active, accept, is_digit;
  logic [35:0] prod;
  logic [1:0] cnt;
  logic [2:0] kinds [0:3];
  logic [2:0] lvls;
  logic [31:0] mag;
  logic mneg;

  assign s_axis_tready = q_ready;
  assign accept = s_axis_tvalid && q_ready;
  assign c = s_axis_tdata[7:0];
  assign lc = (c >= tcme_pkg::CH_UP_A && c <= tcme_pkg::CH_UP_Z) ? c + tcme_pkg::CH_CASE : c;
  assign active = pos < tcme_pkg::POS_W'(tcme_pkg::MAX_WRITE_BYTES);
  assign is_digit = c >= tcme_pkg::CH_ZERO && c <= tcme_pkg::CH_NINE;
  assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, c[3:0]};

  always_comb begin
    pos_next = pos;
    mode_next = mode;
    stopped_next = stopped;
    neg_next = neg;
    acc_next = acc;
    prev_sync_next = prev_sync;
    cnt = 2'd0;
    for (int i = 0; i < 4; i++) begin
      kinds[i] = tcme_pkg::EV_SYNC;
    end
    lvls = 3'b000;
    mag = 32'd0;
    mneg = 1'b0;
    if (active) begin
      pos_next = pos + tcme_pkg::POS_W'(1);
      if (pos == '0) begin
        prev_sync_next = 1'b0;
        unique case (lc)
          tcme_pkg::CH_I: mode_next = tcme_pkg::MODE_SEQ;
          tcme_pkg::CH_X: mode_next = tcme_pkg::MODE_X;
          tcme_pkg::CH_Y: mode_next = tcme_pkg::MODE_Y;
          tcme_pkg::CH_L: begin
            mode_next = tcme_pkg::MODE_LCLICK;
            kinds[0] = tcme_pkg::EV_LEFT;
            lvls[0] = 1'b1;
            kinds[1] = tcme_pkg::EV_LEFT;
            kinds[2] = tcme_pkg::EV_SYNC;
            cnt = 2'd3;
            prev_sync_next = 1'b1;
          end
          tcme_pkg::CH_R: begin
            mode_next = tcme_pkg::MODE_RCLICK;
            kinds[0] = tcme_pkg::EV_RIGHT;
            lvls[0] = 1'b1;
            kinds[1] = tcme_pkg::EV_RIGHT;
            cnt = 2'd2;
          end
          default: mode_next = tcme_pkg::MODE_NONE;
        endcase
      end else if (pos == tcme_pkg::POS_W'(1)) begin
        if (mode == tcme_pkg::MODE_LCLICK && c == tcme_pkg::CH_L) begin
          kinds[0] = tcme_pkg::EV_LEFT;
          lvls[0] = 1'b1;
          kinds[1] = tcme_pkg::EV_LEFT;
          cnt = 2'd2;
          prev_sync_next = 1'b0;
        end
      end else if (mode == tcme_pkg::MODE_SEQ) begin
        if (!stopped) begin
          cnt = 2'd2;
          prev_sync_next = 1'b1;
          kinds[1] = tcme_pkg::EV_SYNC;
          mag = {25'd0, step_distance};
          if (lc == tcme_pkg::CH_U) begin
            kinds[0] = tcme_pkg::EV_MOVE_Y;
            mneg = 1'b1;
          end else if (lc == tcme_pkg::CH_D) begin
            kinds[0] = tcme_pkg::EV_MOVE_Y;
          end else if (lc == tcme_pkg::CH_L) begin
            kinds[0] = tcme_pkg::EV_MOVE_X;
            mneg = 1'b1;
          end else if (lc == tcme_pkg::CH_R) begin
            kinds[0] = tcme_pkg::EV_MOVE_X;
          end else if (c == tcme_pkg::CH_Q) begin
            kinds[0] = tcme_pkg::EV_LEFT;
            lvls[0] = 1'b1;
          end else if (c == tcme_pkg::CH_UP_Q) begin
            kinds[0] = tcme_pkg::EV_LEFT;
          end else if (c == tcme_pkg::CH_W) begin
            kinds[0] = tcme_pkg::EV_RIGHT;
            lvls[0] = 1'b1;
          end else if (c == tcme_pkg::CH_UP_W) begin
            kinds[0] = tcme_pkg::EV_RIGHT;
          end else begin
            cnt = 2'd0;
            prev_sync_next = prev_sync;
            stopped_next = 1'b1;
          end
        end
      end else if (mode == tcme_pkg::MODE_X || mode == tcme_pkg::MODE_Y) begin
        if (pos == tcme_pkg::POS_W'(2) && c == tcme_pkg::CH_MINUS) begin
          neg_next = 1'b1;
        end else if (is_digit) begin
          acc_next = (prod > {4'd0, tcme_pkg::MAG_CAP}) ? tcme_pkg::MAG_CAP : prod[31:0];
        end
      end
    end
    if (s_axis_tlast) begin
      if ((mode_next == tcme_pkg::MODE_X || mode_next == tcme_pkg::MODE_Y) && pos != '0) begin
        kinds[cnt] = (mode_next == tcme_pkg::MODE_X) ? tcme_pkg::EV_MOVE_X
                                                     : tcme_pkg::EV_MOVE_Y;
        mag = acc_next;
        mneg = neg_next;
        cnt = cnt + 2'd1;
        prev_sync_next = 1'b0;
      end
      if (!prev_sync_next) begin
        kinds[cnt] = tcme_pkg::EV_SYNC;
        cnt = cnt + 2'd1;
      end
      pos_next = '0;
      mode_next = tcme_pkg::MODE_NONE;
      stopped_next = 1'b0;
      neg_next = 1'b0;
      acc_next = 32'd0;
      prev_sync_next = 1'b0;
    end
  end

  assign push = accept && cnt != 2'd0;

  always_comb begin
    push_entry.count = cnt;
    push_entry.kind[0] = kinds[0];
    push_entry.kind[1] = kinds[1];
    push_entry.kind[2] = kinds[2];
    push_entry.level = lvls;
    push_entry.mag = mag;
    push_entry.neg = mneg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      mode <= tcme_pkg::MODE_NONE;
      stopped <= 1'b0;
      neg <= 1'b0;
      acc <= 32'd0;
      prev_sync <= 1'b0;
    end else if (accept) begin
      pos <= pos_next;
      mode <= mode_next;
      stopped <= stopped_next;
      neg <= neg_next;
      acc <= acc_next;
      prev_sync <= prev_sync_next;
    end
  end

endmodule

// ===== hdl/tcme_queue.sv =====
module tcme_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tcme_pkg::evt_entry_t push_entry,
  output logic ready,
  output logic valid,
  input  logic pop,
  output tcme_pkg::evt_entry_t pop_entry
);

  tcme_pkg::evt_entry_t slots [0:tcme_pkg::QDEPTH-1];
  logic [tcme_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [tcme_pkg::QCNT_W-1:0] count;
  logic do_push, do_pop;

  assign ready = count != tcme_pkg::QCNT_W'(tcme_pkg::QDEPTH);
  assign valid = count != '0;
  assign do_push = push && ready;
  assign do_pop = pop && valid;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == tcme_pkg::QPTR_W'(tcme_pkg::QDEPTH - 1)) ? '0
                  : wr_ptr + tcme_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == tcme_pkg::QPTR_W'(tcme_pkg::QDEPTH - 1)) ? '0
                  : rd_ptr + tcme_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + tcme_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - tcme_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/tcme_back.sv =====
module tcme_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  tcme_pkg::evt_entry_t q_entry,
  output logic q_pop,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [tcme_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [31:0] event_value
  output logic [tcme_pkg::OUT_TUSER_W-1:0] m_axis_tuser, // [2:0] event_kind
  output logic m_axis_tlast
);

  tcme_pkg::evt_entry_t cur;
  logic cur_valid;
  logic [1:0] idx;
  logic out_free, fire, finish;
  logic [2:0] kind, out_kind;
  logic [31:0] value, out_value;
  logic out_last;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign fire = cur_valid && out_free;
  assign finish = fire && (idx == cur.count - 2'd1);
  assign q_pop = q_valid && (!cur_valid || finish);
  assign kind = cur.kind[idx];

  always_comb begin
    unique case (kind)
      tcme_pkg::EV_MOVE_X, tcme_pkg::EV_MOVE_Y: begin
        if (cur.neg) begin
          value = 32'd0 - cur.mag;
        end else begin
          value = cur.mag[31] ? tcme_pkg::POS_MAX : cur.mag;
        end
      end
      tcme_pkg::EV_LEFT, tcme_pkg::EV_RIGHT: value = {31'd0, cur.level[idx]};
      default: value = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
    if (fire) begin
      out_kind <= kind;
      out_value <= value;
      out_last <= idx == cur.count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 2'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx <= 2'd0;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end else if (fire) begin
        idx <= idx + 2'd1;
      end
      if (fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = out_value;
  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_GAP = 14;

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] value;
    logic last;
  } mouse_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [tcme_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tcme_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [tcme_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tcme_pkg::STEP_W-1:0] cfg_data = '0;

  text_command_to_mouse_events_unit u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // command decoder state mirrored from the block
  logic [tcme_pkg::STEP_W-1:0] pred_step = tcme_pkg::STEP_RESET;
  int pred_pos = 0;
  logic [2:0] pred_mode = tcme_pkg::MODE_NONE;
  logic pred_stopped = 1'b0;
  logic pred_neg = 1'b0;
  logic [31:0] pred_mag = '0;
  logic pred_prev_sync = 1'b0;

  mouse_event_t byte_events[$];
  mouse_event_t pending_events[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_stall = 0;
  int rx_hold = 0;

  int error_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int writes_sent = 0;
  int events_seen = 0;
  int moves_seen = 0;
  int buttons_seen = 0;
  int syncs_seen = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycle_count,
               pending_events.size());
      $display("FAIL text_command_to_mouse_events_unit");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic int draw_gap(input bit on);
    return on ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  function automatic void add_event(input logic [2:0] kind, input logic [31:0] value);
    mouse_event_t ev;
    ev.kind = kind;
    ev.value = value;
    ev.last = 1'b0;
    byte_events.push_back(ev);
    pred_prev_sync = (kind == tcme_pkg::EV_SYNC);
  endfunction

  function automatic void predict_byte(input logic [7:0] ch, input logic eow);
    logic [7:0] low_ch;
    logic [31:0] amount;
    logic [31:0] neg_step;
    logic [31:0] pos_step;
    logic [63:0] wide;
    int pos_in;
    pos_in = pred_pos;
    byte_events.delete();
    low_ch = (ch >= tcme_pkg::CH_UP_A && ch <= tcme_pkg::CH_UP_Z) ? ch + tcme_pkg::CH_CASE
                                                                  : ch;
    pos_step = {25'd0, pred_step};
    neg_step = 32'd0 - pos_step;
    if (pos_in < tcme_pkg::MAX_WRITE_BYTES) begin
      if (pos_in == 0) begin
        pred_prev_sync = 1'b0;
        case (low_ch)
          tcme_pkg::CH_I: pred_mode = tcme_pkg::MODE_SEQ;
          tcme_pkg::CH_X: pred_mode = tcme_pkg::MODE_X;
          tcme_pkg::CH_Y: pred_mode = tcme_pkg::MODE_Y;
          tcme_pkg::CH_L: begin
            pred_mode = tcme_pkg::MODE_LCLICK;
            add_event(tcme_pkg::EV_LEFT, 32'd1);
            add_event(tcme_pkg::EV_LEFT, 32'd0);
            add_event(tcme_pkg::EV_SYNC, 32'd0);
          end
          tcme_pkg::CH_R: begin
            pred_mode = tcme_pkg::MODE_RCLICK;
            add_event(tcme_pkg::EV_RIGHT, 32'd1);
            add_event(tcme_pkg::EV_RIGHT, 32'd0);
          end
          default: pred_mode = tcme_pkg::MODE_NONE;
        endcase
      end else if (pos_in == 1) begin
        if (pred_mode == tcme_pkg::MODE_LCLICK && ch == tcme_pkg::CH_L) begin
          add_event(tcme_pkg::EV_LEFT, 32'd1);
          add_event(tcme_pkg::EV_LEFT, 32'd0);
        end
      end else if (pred_mode == tcme_pkg::MODE_SEQ) begin
        if (!pred_stopped) begin
          if (low_ch == tcme_pkg::CH_U) add_event(tcme_pkg::EV_MOVE_Y, neg_step);
          else if (low_ch == tcme_pkg::CH_D) add_event(tcme_pkg::EV_MOVE_Y, pos_step);
          else if (low_ch == tcme_pkg::CH_L) add_event(tcme_pkg::EV_MOVE_X, neg_step);
          else if (low_ch == tcme_pkg::CH_R) add_event(tcme_pkg::EV_MOVE_X, pos_step);
          else if (ch == tcme_pkg::CH_Q) add_event(tcme_pkg::EV_LEFT, 32'd1);
          else if (ch == tcme_pkg::CH_UP_Q) add_event(tcme_pkg::EV_LEFT, 32'd0);
          else if (ch == tcme_pkg::CH_W) add_event(tcme_pkg::EV_RIGHT, 32'd1);
          else if (ch == tcme_pkg::CH_UP_W) add_event(tcme_pkg::EV_RIGHT, 32'd0);
          else pred_stopped = 1'b1;
          if (!pred_stopped) add_event(tcme_pkg::EV_SYNC, 32'd0);
        end
      end else if (pred_mode == tcme_pkg::MODE_X || pred_mode == tcme_pkg::MODE_Y) begin
        if (pos_in == 2 && ch == tcme_pkg::CH_MINUS) begin
          pred_neg = 1'b1;
        end else if (ch >= tcme_pkg::CH_ZERO && ch <= tcme_pkg::CH_NINE) begin
          wide = {32'd0, pred_mag} * 64'd10 + {56'd0, ch - tcme_pkg::CH_ZERO};
          pred_mag = (wide > {32'd0, tcme_pkg::MAG_CAP}) ? tcme_pkg::MAG_CAP : wide[31:0];
        end
      end
      pred_pos = pos_in + 1;
    end
    if (eow) begin
      if ((pred_mode == tcme_pkg::MODE_X || pred_mode == tcme_pkg::MODE_Y) && pos_in >= 1)
      begin
        if (pred_neg) amount = 32'd0 - pred_mag;
        else amount = (pred_mag > tcme_pkg::POS_MAX) ? tcme_pkg::POS_MAX : pred_mag;
        add_event((pred_mode == tcme_pkg::MODE_X) ? tcme_pkg::EV_MOVE_X : tcme_pkg::EV_MOVE_Y,
                  amount);
      end
      if (!pred_prev_sync) add_event(tcme_pkg::EV_SYNC, 32'd0);
      pred_pos = 0;
      pred_mode = tcme_pkg::MODE_NONE;
      pred_stopped = 1'b0;
      pred_neg = 1'b0;
      pred_mag = '0;
      pred_prev_sync = 1'b0;
    end
    if (byte_events.size() > 0) byte_events[byte_events.size()-1].last = 1'b1;
    foreach (byte_events[i]) pending_events.push_back(byte_events[i]);
  endfunction

  // one transfer on the command side; tvalid stays up until the next falling edge
  task automatic send_byte(input logic [7:0] ch, input logic eow);
    int gap;
    gap = draw_gap(tx_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= eow;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (eow) writes_sent++;
    predict_byte(ch, eow);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i], i == text.len() - 1);
  endtask

  // hold the sender until every expected event is out, then let the pipe settle
  task automatic drain_events();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [tcme_pkg::STEP_W-1:0] value);
    drain_events();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    pred_step = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] sequence_letter();
    case ($urandom_range(0, 11))
      0: return tcme_pkg::CH_U;
      1: return tcme_pkg::CH_D;
      2: return tcme_pkg::CH_L;
      3: return tcme_pkg::CH_R;
      4: return tcme_pkg::CH_U - tcme_pkg::CH_CASE;
      5: return tcme_pkg::CH_D - tcme_pkg::CH_CASE;
      6: return tcme_pkg::CH_L - tcme_pkg::CH_CASE;
      7: return tcme_pkg::CH_R - tcme_pkg::CH_CASE;
      8: return tcme_pkg::CH_Q;
      9: return tcme_pkg::CH_UP_Q;
      10: return tcme_pkg::CH_W;
      default: return tcme_pkg::CH_UP_W;
    endcase
  endfunction

  function automatic logic [7:0] maybe_upper(input logic [7:0] ch);
    return $urandom_range(0, 1) ? ch - tcme_pkg::CH_CASE : ch;
  endfunction

  task automatic send_random_write();
    logic [7:0] cmd[$];
    int pick;
    int n;
    int target_len;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      cmd.push_back(maybe_upper(tcme_pkg::CH_I));
      cmd.push_back(8'($urandom_range(0, 255)));
      n = $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(0, 11) == 0) cmd.push_back(8'($urandom_range(0, 255)));
        else cmd.push_back(sequence_letter());
      end
    end else if (pick < 70) begin
      cmd.push_back(maybe_upper($urandom_range(0, 1) ? tcme_pkg::CH_X : tcme_pkg::CH_Y));
      cmd.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) cmd.push_back(tcme_pkg::CH_MINUS);
      n = $urandom_range(0, 13);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) cmd.push_back(8'($urandom_range(0, 255)));
        else cmd.push_back(tcme_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end else if (pick < 80) begin
      cmd.push_back(maybe_upper(tcme_pkg::CH_L));
      if ($urandom_range(0, 2) != 0)
        cmd.push_back($urandom_range(0, 1) ? tcme_pkg::CH_L : 8'($urandom_range(0, 255)));
      n = $urandom_range(0, 2);
      repeat (n) cmd.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 87) begin
      cmd.push_back(maybe_upper(tcme_pkg::CH_R));
      n = $urandom_range(0, 2);
      repeat (n) cmd.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) cmd.push_back(8'($urandom_range(0, 255)));
    end
    // occasionally run past the byte limit of one write
    if ($urandom_range(0, 9) == 0) begin
      target_len = $urandom_range(tcme_pkg::MAX_WRITE_BYTES + 1,
                                  tcme_pkg::MAX_WRITE_BYTES + 6);
      while (cmd.size() < target_len)
        cmd.push_back($urandom_range(0, 1) ? sequence_letter()
                                           : tcme_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    foreach (cmd[i]) send_byte(cmd[i], i == cmd.size() - 1);
  endtask

  task automatic run_random_bytes(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_write();
  endtask

  task automatic test_directed_writes();
    send_text("iXUdLrqQwW!u");
    send_text("x?-");
    send_text("Y7a9");
    send_text("ll");
    send_text("l");
    send_text("R");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("x");
  endtask

  task automatic test_step_settings();
    write_step('0);
    run_random_bytes(25);
    write_step({tcme_pkg::STEP_W{1'b1}});
    run_random_bytes(25);
    write_step(7'd1);
    run_random_bytes(25);
    write_step(7'($urandom_range(2, 126)));
    run_random_bytes(25);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 4; i++) begin
      tx_idle_on = (i == 0 || i == 2);
      rx_idle_on = (i == 0 || i == 3);
      run_random_bytes(20);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_hold = 300;
    send_text("i.udlrqQwWUDLRudlr");
    run_random_bytes(10);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    run_random_bytes(10);
    drain_events();
    run_random_bytes(10);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_events
    mouse_event_t got;
    mouse_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser[2:0];
      got.value = m_axis_tdata[31:0];
      got.last = m_axis_tlast;
      events_seen++;
      if (got.kind == tcme_pkg::EV_MOVE_X || got.kind == tcme_pkg::EV_MOVE_Y) moves_seen++;
      else if (got.kind == tcme_pkg::EV_SYNC) syncs_seen++;
      else buttons_seen++;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d value %0d last %0b",
                                  got.kind, $signed(got.value), got.last));
      end else begin
        want = pending_events.pop_front();
        if (got.kind != want.kind || got.value != want.value || got.last != want.last)
          report_mismatch($sformatf(
            "event %0d: kind %0d/%0d value %0d/%0d last %0b/%0b (got/expected)",
            events_seen, got.kind, want.kind, $signed(got.value), $signed(want.value),
            got.last, want.last));
      end
      rx_stall = draw_gap(rx_idle_on);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_writes();
    test_step_settings();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    rx_idle_on = 1'b0;
    drain_events();
    $display("Ran %0d command bytes in %0d writes; checked %0d events", bytes_sent,
             writes_sent, events_seen);
    $display("  %0d moves, %0d button levels, %0d syncs; steps 10, 0, 127, 1 and random",
             moves_seen, buttons_seen, syncs_seen);
    if (error_count == 0) begin
      $display("PASS text_command_to_mouse_events_unit");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL text_command_to_mouse_events_unit");
    end
    $finish;
  end

endmodule
